/* hw/rtl/clnbd_pkg.sv */
package clnbd_pkg;

   // field widths
   localparam int CMD_W   = 3;
   localparam int BYTE_W  = 8;
   localparam int MOVE_W  = 16;
   localparam int WAIT_W  = 20;
   localparam int ADDR_W  = 7;
   localparam int REG_W   = 3;
   localparam int OPS_W   = 4;
   localparam int POS_W   = 3;

   typedef enum logic [CMD_W-1:0] {
      CMD_INIT      = 3'd0,
      CMD_CHAR      = 3'd1,
      CMD_MOVE      = 3'd2,
      CMD_SETPOS    = 3'd3,
      CMD_CLEAR     = 3'd4,
      CMD_HOME      = 3'd5,
      CMD_TOGGLES   = 3'd6,
      CMD_LINE_MODE = 3'd7
   } cmd_type;

   // configuration register indexes
   localparam logic [REG_W-1:0] REG_BACKLIGHT = 3'd0;
   localparam logic [REG_W-1:0] REG_DISPLAY   = 3'd1;
   localparam logic [REG_W-1:0] REG_CURSOR    = 3'd2;
   localparam logic [REG_W-1:0] REG_BLINK     = 3'd3;
   localparam logic [REG_W-1:0] REG_TWO_LINE  = 3'd4;

   // raw expander byte, one nibble, or a full LCD byte
   typedef enum logic [1:0] {
      OP_RAW  = 2'd0,
      OP_NIB  = 2'd1,
      OP_BYTE = 2'd2
   } op_kind_type;

   // LCD instruction codes
   localparam logic [BYTE_W-1:0] LCD_CLEAR    = 8'h01;
   localparam logic [BYTE_W-1:0] LCD_HOME     = 8'h02;
   localparam logic [BYTE_W-1:0] LCD_TOGGLES  = 8'h08;
   localparam logic [BYTE_W-1:0] LCD_FUNC_SET = 8'h20;
   localparam logic [BYTE_W-1:0] LCD_WAKE     = 8'h30;
   localparam logic [BYTE_W-1:0] LCD_SET_ADDR = 8'h80;

   // waits in microseconds
   localparam logic [WAIT_W-1:0] WAIT_POWER  = 20'd1000000;
   localparam logic [WAIT_W-1:0] WAIT_WAKE   = 20'd4600;
   localparam logic [WAIT_W-1:0] WAIT_LONG   = 20'd2000;
   localparam logic [WAIT_W-1:0] WAIT_CMD    = 20'd40;
   localparam logic [WAIT_W-1:0] WAIT_ENABLE = 20'd1;
   localparam logic [WAIT_W-1:0] WAIT_NONE   = 20'd0;

   // address map
   localparam logic [7:0] ONE_LINE_LEN = 8'h50;
   localparam logic [7:0] ROW0_LEN     = 8'h28;
   localparam logic [7:0] ROW1_BASE    = 8'h40;
   localparam logic [7:0] ROW1_LIMIT   = 8'h68;
   localparam logic [7:0] ROW_GAP      = 8'h18;

   // floor(x/5) = (x * RECIP5) >> 16 for x below 4096
   localparam logic [13:0] RECIP5 = 14'd13108;

   localparam logic [OPS_W-1:0] INIT_OPS = 4'd9;
   localparam logic [OPS_W-1:0] LINE_OPS = 4'd3;

   typedef struct packed {
      logic             capture;
      logic             calc;
      logic             update;
      logic             emit;
      logic             last;
      logic [OPS_W-1:0] op_idx;
      logic [POS_W-1:0] pos;
   } ctrl_cmd_type;

   typedef struct packed {
      logic [OPS_W-1:0] n_ops;
      logic             pos_last;
      logic             out_free;
   } dp_sts_type;

endpackage

/* hw/rtl/clnbd_req_if.sv */
interface clnbd_req_if;
   logic                                    valid;
   logic                                    ready;
   logic [clnbd_pkg::CMD_W-1:0]             command;
   logic [clnbd_pkg::BYTE_W-1:0]            char_code;
   logic signed [clnbd_pkg::MOVE_W-1:0]     move_amount;
   logic [clnbd_pkg::BYTE_W-1:0]            line_number;
   logic [clnbd_pkg::BYTE_W-1:0]            column;

   modport source (output valid, command, char_code, move_amount, line_number, column,
                   input ready);
   modport sink   (input valid, command, char_code, move_amount, line_number, column,
                   output ready);
endinterface

/* hw/rtl/clnbd_rsp_if.sv */
interface clnbd_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [clnbd_pkg::BYTE_W-1:0]  expander_byte;
   logic [clnbd_pkg::WAIT_W-1:0]  wait_us;
   logic [clnbd_pkg::ADDR_W-1:0]  cursor_address;
   logic                          last;

   modport source (output valid, expander_byte, wait_us, cursor_address, last,
                   input ready);
   modport sink   (input valid, expander_byte, wait_us, cursor_address, last,
                   output ready);
endinterface

/* hw/rtl/clnbd_csr_if.sv */
interface clnbd_csr_if;
   logic                         valid;
   logic                         ready;
   logic [clnbd_pkg::REG_W-1:0]  index;
   logic                         data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

/* hw/rtl/clnbd_ctrl.sv */
module clnbd_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  clnbd_pkg::dp_sts_type    sts,
   output clnbd_pkg::ctrl_cmd_type  cmd
);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_CALC = 4'b0010,
      ST_ADDR = 4'b0100,
      ST_EMIT = 4'b1000
   } state_type;

   state_type                        state_ff, state_in;
   logic [clnbd_pkg::OPS_W-1:0]      op_idx_ff, op_idx_in;
   logic [clnbd_pkg::POS_W-1:0]      pos_ff, pos_in;
   logic                             op_last;

   assign op_last = (op_idx_ff == (sts.n_ops - 4'd1));

   always_comb begin
      state_in    = state_ff;
      op_idx_in   = op_idx_ff;
      pos_in      = pos_ff;
      req_ready   = 1'b0;
      cmd         = '0;
      cmd.op_idx  = op_idx_ff;
      cmd.pos     = pos_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_CALC;
            end
         end
         ST_CALC: begin
            cmd.calc = 1'b1;
            state_in = ST_ADDR;
         end
         ST_ADDR: begin
            cmd.update = 1'b1;
            op_idx_in  = '0;
            pos_in     = '0;
            state_in   = ST_EMIT;
         end
         ST_EMIT: begin
            // no ops: invalid position, nothing to send
            if (sts.n_ops == '0) begin
               state_in = ST_IDLE;
            end else if (sts.out_free) begin
               cmd.emit = 1'b1;
               cmd.last = op_last && sts.pos_last;
               if (sts.pos_last) begin
                  pos_in = '0;
                  if (op_last) begin
                     op_idx_in = '0;
                     state_in  = ST_IDLE;
                  end else begin
                     op_idx_in = op_idx_ff + 4'd1;
                  end
               end else begin
                  pos_in = pos_ff + 3'd1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         op_idx_ff <= '0;
         pos_ff    <= '0;
      end else begin
         state_ff  <= state_in;
         op_idx_ff <= op_idx_in;
         pos_ff    <= pos_in;
      end
   end

endmodule

/* hw/rtl/clnbd_dp.sv */
module clnbd_dp (
   input  logic                                 clock,
   input  logic                                 reset,
   input  clnbd_pkg::ctrl_cmd_type              cmd,
   output clnbd_pkg::dp_sts_type                sts,
   input  logic [clnbd_pkg::CMD_W-1:0]          req_command,
   input  logic [clnbd_pkg::BYTE_W-1:0]         req_char_code,
   input  logic signed [clnbd_pkg::MOVE_W-1:0]  req_move_amount,
   input  logic [clnbd_pkg::BYTE_W-1:0]         req_line_number,
   input  logic [clnbd_pkg::BYTE_W-1:0]         req_column,
   input  logic                                 csr_write,
   input  logic [clnbd_pkg::REG_W-1:0]          csr_index,
   input  logic                                 csr_data,
   input  logic                                 rsp_ready,
   output logic                                 rsp_valid,
   output logic [clnbd_pkg::BYTE_W-1:0]         rsp_expander_byte,
   output logic [clnbd_pkg::WAIT_W-1:0]         rsp_wait_us,
   output logic [clnbd_pkg::ADDR_W-1:0]         rsp_cursor_address,
   output logic                                 rsp_last
);

   // configuration
   logic backlight_ff, backlight_in;
   logic display_ff, display_in;
   logic cursor_ff, cursor_in;
   logic blink_ff, blink_in;
   logic two_line_ff, two_line_in;

   // captured item
   logic [clnbd_pkg::CMD_W-1:0]   command_ff, command_in;
   logic [clnbd_pkg::BYTE_W-1:0]  char_ff, char_in;
   logic [clnbd_pkg::MOVE_W-1:0]  move_ff, move_in;
   logic [clnbd_pkg::BYTE_W-1:0]  line_ff, line_in;
   logic [clnbd_pkg::BYTE_W-1:0]  column_ff, column_in;

   // move distance, 0..79
   logic [6:0]   dist_ff, dist_in;
   logic [11:0]  mv_hi;
   logic [25:0]  prod;
   logic [9:0]   quo;
   logic [11:0]  quo5;
   logic [2:0]   rem5;
   logic [6:0]   mod_u;
   logic [6:0]   mod_s;

   // address tracking and op count
   logic [clnbd_pkg::ADDR_W-1:0]  addr_ff, addr_in;
   logic [clnbd_pkg::OPS_W-1:0]   n_ops_ff, n_ops_in;
   logic [clnbd_pkg::ADDR_W-1:0]  addr_next;
   logic [clnbd_pkg::OPS_W-1:0]   n_ops_next;

   // current op
   clnbd_pkg::op_kind_type        op_kind;
   logic [clnbd_pkg::BYTE_W-1:0]  op_value;
   logic                          op_rs;
   logic [clnbd_pkg::WAIT_W-1:0]  op_wait;
   logic [clnbd_pkg::BYTE_W-1:0]  set_addr_val;
   logic [clnbd_pkg::BYTE_W-1:0]  func_set_val;
   logic [clnbd_pkg::BYTE_W-1:0]  toggles_val;
   logic [3:0]                    nib;
   logic                          enable;
   logic                          pos_last;
   logic [clnbd_pkg::BYTE_W-1:0]  byte_out;
   logic [clnbd_pkg::WAIT_W-1:0]  wait_out;

   // output register
   logic                          valid_ff, valid_in;
   logic [clnbd_pkg::BYTE_W-1:0]  byte_ff, byte_in;
   logic [clnbd_pkg::WAIT_W-1:0]  wait_ff, wait_in;
   logic [clnbd_pkg::ADDR_W-1:0]  caddr_ff, caddr_in;
   logic                          last_ff, last_in;
   logic                          out_free;

   always_comb begin
      backlight_in = backlight_ff;
      display_in   = display_ff;
      cursor_in    = cursor_ff;
      blink_in     = blink_ff;
      two_line_in  = two_line_ff;
      if (csr_write) begin
         unique case (csr_index)
            clnbd_pkg::REG_BACKLIGHT: backlight_in = csr_data;
            clnbd_pkg::REG_DISPLAY:   display_in   = csr_data;
            clnbd_pkg::REG_CURSOR:    cursor_in    = csr_data;
            clnbd_pkg::REG_BLINK:     blink_in     = csr_data;
            clnbd_pkg::REG_TWO_LINE:  two_line_in  = csr_data;
            default: ;
         endcase
      end
   end

   assign command_in = cmd.capture ? req_command     : command_ff;
   assign char_in    = cmd.capture ? req_char_code   : char_ff;
   assign move_in    = cmd.capture ? req_move_amount : move_ff;
   assign line_in    = cmd.capture ? req_line_number : line_ff;
   assign column_in  = cmd.capture ? req_column      : column_ff;

   // unsigned mod 80 = 16 * ((x >> 4) mod 5) + (x & 15);
   // the sign weight -65536 is -16 mod 80
   assign mv_hi = move_ff[15:4];
   assign prod  = 26'(mv_hi) * 26'(clnbd_pkg::RECIP5);
   assign quo   = prod[25:16];
   assign quo5  = {quo, 2'b00} + {2'b00, quo};
   assign rem5  = mv_hi[2:0] - quo5[2:0];
   assign mod_u = {rem5, move_ff[3:0]};

   always_comb begin
      if (!move_ff[15]) begin
         mod_s = mod_u;
      end else if (mod_u < 7'd16) begin
         mod_s = mod_u + 7'd64;
      end else begin
         mod_s = mod_u - 7'd16;
      end
   end

   assign dist_in = cmd.calc ? mod_s : dist_ff;

   always_comb begin
      logic [7:0] a;
      logic [7:0] m;
      a          = {1'b0, addr_ff};
      m          = a;
      addr_next  = addr_ff;
      n_ops_next = 4'd1;
      unique case (clnbd_pkg::cmd_type'(command_ff))
         clnbd_pkg::CMD_CHAR: begin
            m = a + 8'd1;
            if (!two_line_ff) begin
               if (m >= clnbd_pkg::ONE_LINE_LEN) begin
                  m          = m - clnbd_pkg::ONE_LINE_LEN;
                  n_ops_next = 4'd2;
               end
            end else if (m >= clnbd_pkg::ROW0_LEN && m < clnbd_pkg::ROW1_BASE) begin
               m          = m + clnbd_pkg::ROW_GAP;
               n_ops_next = 4'd2;
            end else if (m >= clnbd_pkg::ROW1_LIMIT) begin
               m          = m - clnbd_pkg::ROW1_LIMIT;
               n_ops_next = 4'd2;
            end
            addr_next = m[6:0];
         end
         clnbd_pkg::CMD_MOVE: begin
            m = a + {1'b0, dist_ff};
            if (!two_line_ff) begin
               if (m >= clnbd_pkg::ONE_LINE_LEN) begin
                  m = m - clnbd_pkg::ONE_LINE_LEN;
               end
            end else if (a < clnbd_pkg::ROW0_LEN) begin
               if (m >= clnbd_pkg::ROW0_LEN) begin
                  m = m + clnbd_pkg::ROW_GAP;
                  if (m >= clnbd_pkg::ROW1_LIMIT) begin
                     m = m - clnbd_pkg::ROW1_LIMIT;
                  end
               end
            end else if (m >= clnbd_pkg::ROW1_LIMIT) begin
               m = m - clnbd_pkg::ROW1_LIMIT;
               if (m >= clnbd_pkg::ROW0_LEN) begin
                  m = m + clnbd_pkg::ROW_GAP;
               end
            end
            addr_next = m[6:0];
         end
         clnbd_pkg::CMD_SETPOS: begin
            n_ops_next = 4'd0;
            if (line_ff == 8'd0) begin
               if ((column_ff < clnbd_pkg::ONE_LINE_LEN && !two_line_ff) ||
                   column_ff < clnbd_pkg::ROW0_LEN) begin
                  addr_next  = column_ff[6:0];
                  n_ops_next = 4'd1;
               end
            end else if (line_ff == 8'd1 && two_line_ff && column_ff < clnbd_pkg::ROW0_LEN) begin
               m          = column_ff + clnbd_pkg::ROW1_BASE;
               addr_next  = m[6:0];
               n_ops_next = 4'd1;
            end
         end
         clnbd_pkg::CMD_TOGGLES: begin
            addr_next = addr_ff;
         end
         clnbd_pkg::CMD_INIT: begin
            addr_next  = '0;
            n_ops_next = clnbd_pkg::INIT_OPS;
         end
         clnbd_pkg::CMD_LINE_MODE: begin
            addr_next  = '0;
            n_ops_next = clnbd_pkg::LINE_OPS;
         end
         clnbd_pkg::CMD_CLEAR, clnbd_pkg::CMD_HOME: begin
            addr_next = '0;
         end
         default: begin
            addr_next = addr_ff;
         end
      endcase
   end

   assign addr_in  = cmd.update ? addr_next  : addr_ff;
   assign n_ops_in = cmd.update ? n_ops_next : n_ops_ff;

   assign set_addr_val = clnbd_pkg::LCD_SET_ADDR | {1'b0, addr_ff};
   assign func_set_val = clnbd_pkg::LCD_FUNC_SET | {4'd0, two_line_ff, 3'd0};
   assign toggles_val  = clnbd_pkg::LCD_TOGGLES | {5'd0, display_ff, cursor_ff, blink_ff};

   // op sequence per command
   always_comb begin
      op_kind  = clnbd_pkg::OP_BYTE;
      op_value = set_addr_val;
      op_rs    = 1'b0;
      op_wait  = clnbd_pkg::WAIT_CMD;
      unique case (clnbd_pkg::cmd_type'(command_ff))
         clnbd_pkg::CMD_INIT: begin
            unique case (cmd.op_idx)
               4'd0: begin
                  op_kind  = clnbd_pkg::OP_RAW;
                  op_value = '0;
                  op_wait  = clnbd_pkg::WAIT_POWER;
               end
               4'd1, 4'd2, 4'd3: begin
                  op_kind  = clnbd_pkg::OP_NIB;
                  op_value = clnbd_pkg::LCD_WAKE;
                  op_wait  = clnbd_pkg::WAIT_WAKE;
               end
               4'd4: begin
                  op_kind  = clnbd_pkg::OP_NIB;
                  op_value = clnbd_pkg::LCD_FUNC_SET;
                  op_wait  = clnbd_pkg::WAIT_NONE;
               end
               4'd5: op_value = func_set_val;
               4'd6: op_value = toggles_val;
               4'd7: begin
                  op_value = clnbd_pkg::LCD_CLEAR;
                  op_wait  = clnbd_pkg::WAIT_LONG;
               end
               default: begin
                  op_value = clnbd_pkg::LCD_HOME;
                  op_wait  = clnbd_pkg::WAIT_LONG;
               end
            endcase
         end
         clnbd_pkg::CMD_CHAR: begin
            if (cmd.op_idx == 4'd0) begin
               op_value = char_ff;
               op_rs    = 1'b1;
               op_wait  = clnbd_pkg::WAIT_NONE;
            end
         end
         clnbd_pkg::CMD_MOVE, clnbd_pkg::CMD_SETPOS: begin
            op_value = set_addr_val;
         end
         clnbd_pkg::CMD_CLEAR: begin
            op_value = clnbd_pkg::LCD_CLEAR;
            op_wait  = clnbd_pkg::WAIT_LONG;
         end
         clnbd_pkg::CMD_HOME: begin
            op_value = clnbd_pkg::LCD_HOME;
            op_wait  = clnbd_pkg::WAIT_LONG;
         end
         clnbd_pkg::CMD_TOGGLES: begin
            op_value = toggles_val;
         end
         clnbd_pkg::CMD_LINE_MODE: begin
            unique case (cmd.op_idx)
               4'd0: begin
                  op_value = clnbd_pkg::LCD_CLEAR;
                  op_wait  = clnbd_pkg::WAIT_LONG;
               end
               4'd1: op_value = func_set_val;
               default: begin
                  op_value = clnbd_pkg::LCD_HOME;
                  op_wait  = clnbd_pkg::WAIT_LONG;
               end
            endcase
         end
         default: ;
      endcase
   end

   // expander byte within the op: nibble, enable high, enable low (twice for a full byte)
   assign nib    = (cmd.pos < 3'd3) ? op_value[7:4] : op_value[3:0];
   assign enable = (cmd.pos == 3'd1) || (cmd.pos == 3'd4);

   always_comb begin
      unique case (op_kind)
         clnbd_pkg::OP_RAW: pos_last = (cmd.pos == 3'd0);
         clnbd_pkg::OP_NIB: pos_last = (cmd.pos == 3'd2);
         default:           pos_last = (cmd.pos == 3'd5);
      endcase
   end

   always_comb begin
      if (op_kind == clnbd_pkg::OP_RAW) begin
         byte_out = op_value;
      end else begin
         byte_out = {nib, backlight_ff, enable, 1'b0, op_rs};
      end
      if (pos_last) begin
         wait_out = op_wait;
      end else if (enable) begin
         wait_out = clnbd_pkg::WAIT_ENABLE;
      end else begin
         wait_out = clnbd_pkg::WAIT_NONE;
      end
   end

   assign out_free = !valid_ff || rsp_ready;

   always_comb begin
      byte_in  = byte_ff;
      wait_in  = wait_ff;
      caddr_in = caddr_ff;
      last_in  = last_ff;
      valid_in = valid_ff && !rsp_ready;
      if (cmd.emit) begin
         byte_in  = byte_out;
         wait_in  = wait_out;
         caddr_in = addr_ff;
         last_in  = cmd.last;
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         backlight_ff <= 1'b1;
         display_ff   <= 1'b1;
         cursor_ff    <= 1'b0;
         blink_ff     <= 1'b0;
         two_line_ff  <= 1'b1;
         addr_ff      <= '0;
         n_ops_ff     <= '0;
         valid_ff     <= 1'b0;
      end else begin
         backlight_ff <= backlight_in;
         display_ff   <= display_in;
         cursor_ff    <= cursor_in;
         blink_ff     <= blink_in;
         two_line_ff  <= two_line_in;
         addr_ff      <= addr_in;
         n_ops_ff     <= n_ops_in;
         valid_ff     <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      command_ff <= command_in;
      char_ff    <= char_in;
      move_ff    <= move_in;
      line_ff    <= line_in;
      column_ff  <= column_in;
      dist_ff    <= dist_in;
      byte_ff    <= byte_in;
      wait_ff    <= wait_in;
      caddr_ff   <= caddr_in;
      last_ff    <= last_in;
   end

   assign sts.n_ops    = n_ops_ff;
   assign sts.pos_last = pos_last;
   assign sts.out_free = out_free;

   assign rsp_valid          = valid_ff;
   assign rsp_expander_byte  = byte_ff;
   assign rsp_wait_us        = wait_ff;
   assign rsp_cursor_address = caddr_ff;
   assign rsp_last           = last_ff;

endmodule

/* hw/rtl/char_lcd_nibble_bus_driver.sv */
// Each accepted item goes through capture, move reduction and address update; its
//   expander bytes then leave through the output register at one per cycle while rsp is
//   ready, the emit sequencer setting the pace; the next item is taken once its last byte is emitted.
// Reset (synchronous, active high): idle, address 0, backlight/display/two-line on,
//   cursor and blink off, output register empty.
module char_lcd_nibble_bus_driver (
   input logic          clock,
   input logic          reset,
   clnbd_req_if.sink    req_if,
   clnbd_rsp_if.source  rsp_if,
   clnbd_csr_if.sink    csr_if
);

   // controller and datapath talk only through these two structs
   clnbd_pkg::ctrl_cmd_type  ctl_cmd;
   clnbd_pkg::dp_sts_type    dp_sts;
   logic                     req_ready;

   // register writes are taken at any time and go straight into the config registers
   assign csr_if.ready = 1'b1;
   assign req_if.ready = req_ready;

   // sequencer: idle -> capture -> move reduction -> address update -> byte emission.
   // Once the last byte sits in the output register it returns to idle, so the next
   // item is accepted while that byte still waits for the sink.
   clnbd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_ready),
      .sts       (dp_sts),
      .cmd       (ctl_cmd)
   );

   // datapath: config registers, item capture, mod-80 reduction (one small multiply),
   // address tracking with row wrap, op decode per command and the output register
   clnbd_dp u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (ctl_cmd),
      .sts                (dp_sts),
      .req_command        (req_if.command),
      .req_char_code      (req_if.char_code),
      .req_move_amount    (req_if.move_amount),
      .req_line_number    (req_if.line_number),
      .req_column         (req_if.column),
      .csr_write          (csr_if.valid),
      .csr_index          (csr_if.index),
      .csr_data           (csr_if.data),
      .rsp_ready          (rsp_if.ready),
      .rsp_valid          (rsp_if.valid),
      .rsp_expander_byte  (rsp_if.expander_byte),
      .rsp_wait_us        (rsp_if.wait_us),
      .rsp_cursor_address (rsp_if.cursor_address),
      .rsp_last           (rsp_if.last)
   );

`ifndef SYNTHESIS
   // one item at a time: busy right after acceptance
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_if.valid && req_if.ready |=> !req_if.ready)
      else $error("item accepted while the previous one is still being expanded");

   // never overwrite a byte the sink has not taken
   a_emit_into_free: assert property (@(posedge clock) disable iff (reset)
      ctl_cmd.emit |-> dp_sts.out_free)
      else $error("expander byte emitted over an untaken byte");

   // the final byte of a run frees the input side
   a_idle_after_last: assert property (@(posedge clock) disable iff (reset)
      ctl_cmd.emit && ctl_cmd.last |=> req_if.ready)
      else $error("sequencer did not return to idle after the final byte");

   // an emitted final byte appears on the port marked as such
   a_last_flag: assert property (@(posedge clock) disable iff (reset)
      ctl_cmd.emit |=> rsp_if.valid && (rsp_if.last == $past(ctl_cmd.last)))
      else $error("output register lost an emitted byte or its final marker");
`endif

endmodule

/* tb/sv/char_lcd_nibble_bus_driver_tb.sv */
`timescale 1ns / 100ps

module char_lcd_nibble_bus_driver_tb;
   import clnbd_pkg::*;

   // expander byte bits: register select, enable strobe, backlight
   localparam logic [7:0] XB_RS = 8'h01;
   localparam logic [7:0] XB_EN = 8'h04;
   localparam logic [7:0] XB_BL = 8'h08;
   // function set: two-line bit
   localparam logic [7:0] FS_TWO_LINE = 8'h08;

   localparam int PHASE_ITEMS  = 64;      // random items per configuration phase
   localparam int DRAIN_CYCLES = 60;      // quiet time after the last expected byte of a phase
   localparam int HOLD_CYCLES  = 400;     // receiver hold-off to back the block up
   localparam int HOLD_AFTER   = 120;     // items accepted before the hold-off starts
   localparam int CYCLE_LIMIT  = 1000000;

   typedef struct {
      cmd_type            cmd;
      logic [7:0]         ch;
      logic signed [15:0] mv;
      logic [7:0]         line_no;
      logic [7:0]         col;
   } lcd_cmd_s;

   typedef struct {
      logic [7:0]  xbyte;
      logic [19:0] wait_us;
      logic [6:0]  addr;
      logic        last;
   } lcd_out_s;

   // Keeps its own copy of the registers and the tracked address, expands each
   // accepted command into its run of expander bytes and checks them in order.
   class lcd_scoreboard;
      bit         backlight, display, cursor, blink, two_line;
      bit [6:0]   address;
      lcd_out_s   expected[$];
      lcd_out_s   run[$];
      int         errors;

      function new();
         backlight = 1'b1;
         display   = 1'b1;
         cursor    = 1'b0;
         blink     = 1'b0;
         two_line  = 1'b1;
         address   = '0;
         errors    = 0;
      endfunction

      function void write_reg(logic [REG_W-1:0] idx, bit v);
         case (idx)
            REG_BACKLIGHT: backlight = v;
            REG_DISPLAY:   display   = v;
            REG_CURSOR:    cursor    = v;
            REG_BLINK:     blink     = v;
            REG_TWO_LINE:  two_line  = v;
            default: ;
         endcase
      endfunction

      function void push(logic [7:0] b, logic [19:0] w);
         lcd_out_s o;
         o.xbyte   = b;
         o.wait_us = w;
         o.addr    = '0;
         o.last    = 1'b0;
         run.push_back(o);
      endfunction

      // nibble, strobe high, strobe low
      function void nibble(logic [7:0] d);
         logic [7:0] bl;
         bl = backlight ? XB_BL : 8'h00;
         push(d | bl, WAIT_NONE);
         push(d | XB_EN | bl, WAIT_ENABLE);
         push((d & ~XB_EN) | bl, WAIT_NONE);
      endfunction

      function void lcd_byte(logic [7:0] v, logic [7:0] rs, logic [19:0] w);
         nibble({v[7:4], 4'h0} | rs);
         nibble({v[3:0], 4'h0} | rs);
         run[$].wait_us = w;
      endfunction

      function void set_address();
         lcd_byte(LCD_SET_ADDR | {1'b0, address}, 8'h00, WAIT_CMD);
      endfunction

      function void func_set();
         lcd_byte(LCD_FUNC_SET | (two_line ? FS_TWO_LINE : 8'h00), 8'h00, WAIT_CMD);
      endfunction

      function void toggles();
         lcd_byte(LCD_TOGGLES | {5'b0, display, cursor, blink}, 8'h00, WAIT_CMD);
      endfunction

      function void clear_cmd();
         lcd_byte(LCD_CLEAR, 8'h00, WAIT_LONG);
         address = '0;
      endfunction

      function void home_cmd();
         lcd_byte(LCD_HOME, 8'h00, WAIT_LONG);
         address = '0;
      endfunction

      function void note_command(lcd_cmd_s c);
         int a, s, d;
         run.delete();
         a = int'(address);
         case (c.cmd)
            CMD_INIT: begin
               push(8'h00, WAIT_POWER);
               repeat (3) begin
                  nibble(LCD_WAKE);
                  run[$].wait_us = WAIT_WAKE;
               end
               nibble(LCD_FUNC_SET);
               func_set();
               toggles();
               clear_cmd();
               home_cmd();
            end
            CMD_CHAR: begin
               lcd_byte(c.ch, XB_RS, WAIT_NONE);
               a = a + 1;
               if (!two_line) begin
                  if (a >= ONE_LINE_LEN) begin
                     while (a >= ONE_LINE_LEN) a -= ONE_LINE_LEN;
                     address = 7'(a);
                     set_address();
                  end else begin
                     address = 7'(a);
                  end
               end else if (a >= ROW0_LEN && a < ROW1_BASE) begin
                  address = 7'(a + ROW_GAP);
                  set_address();
               end else if (a >= ROW1_LIMIT) begin
                  a -= ROW1_LIMIT;
                  while (a >= ROW0_LEN) a -= ROW0_LEN;
                  address = 7'(a);
                  set_address();
               end else begin
                  address = 7'(a);
               end
            end
            CMD_MOVE: begin
               s = int'(c.mv);
               d = s % 80;
               if (d < 0) d += 80;
               if (!two_line) begin
                  a += d;
                  if (a >= ONE_LINE_LEN) a -= ONE_LINE_LEN;
               end else if (a < ROW0_LEN) begin
                  a += d;
                  if (a >= ROW0_LEN) begin
                     a += ROW_GAP;
                     if (a >= ROW1_LIMIT) a -= ROW1_LIMIT;
                  end
               end else begin
                  a += d;
                  if (a >= ROW1_LIMIT) begin
                     a -= ROW1_LIMIT;
                     if (a >= ROW0_LEN) a += ROW_GAP;
                  end
               end
               address = 7'(a);
               set_address();
            end
            CMD_SETPOS: begin
               if (c.line_no == 8'd0) begin
                  if ((c.col < ONE_LINE_LEN && !two_line) || c.col < ROW0_LEN) begin
                     address = c.col[6:0];
                     set_address();
                  end
               end else if (c.line_no == 8'd1 && two_line) begin
                  if (c.col < ROW0_LEN) begin
                     address = 7'(c.col + ROW1_BASE);
                     set_address();
                  end
               end
            end
            CMD_CLEAR:   clear_cmd();
            CMD_HOME:    home_cmd();
            CMD_TOGGLES: toggles();
            CMD_LINE_MODE: begin
               clear_cmd();
               func_set();
               home_cmd();
            end
            default: ;
         endcase
         foreach (run[i]) begin
            run[i].addr = address;
            run[i].last = (i == run.size() - 1);
            expected.push_back(run[i]);
         end
      endfunction

      task report(string what, int got, int want);
         errors++;
         if (errors <= 200)
            $display("%0t mismatch on %s: got 0x%0h, want 0x%0h", $time, what, got, want);
      endtask

      task check_byte(lcd_out_s got);
         lcd_out_s want;
         if (expected.size() == 0) begin
            report("unexpected expander byte", got.xbyte, 0);
            return;
         end
         want = expected.pop_front();
         if (got.xbyte !== want.xbyte)     report("expander_byte", got.xbyte, want.xbyte);
         if (got.wait_us !== want.wait_us) report("wait_us", got.wait_us, want.wait_us);
         if (got.addr !== want.addr)       report("cursor_address", got.addr, want.addr);
         if (got.last !== want.last)       report("last", got.last, want.last);
      endtask
   endclass

   logic clock;
   logic reset;

   clnbd_req_if req_bus();
   clnbd_rsp_if rsp_bus();
   clnbd_csr_if csr_bus();

   char_lcd_nibble_bus_driver i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus),
      .csr_if (csr_bus)
   );

   lcd_scoreboard sb = new();

   bit no_idle  = 1'b0;   // both sides run flat out while set
   bit hold_rsp = 1'b0;   // receiver hold-off in progress
   int items_accepted = 0;
   int cycle_count    = 0;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Watchdog: a hung handshake ends the run here.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("char_lcd_nibble_bus_driver_tb: errors");
         $finish;
      end
   end

   // Receiver: ready changes on the falling edge, roughly a third of cycles idle.
   always @(negedge clock) begin
      if (!reset)
         rsp_bus.ready = !hold_rsp && (no_idle || $urandom_range(99) >= 34);
   end

   // Results are sampled at the rising edge and checked against the oldest expectation.
   always @(posedge clock) begin
      lcd_out_s got;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got.xbyte   = rsp_bus.expander_byte;
         got.wait_us = rsp_bus.wait_us;
         got.addr    = rsp_bus.cursor_address;
         got.last    = rsp_bus.last;
         sb.check_byte(got);
      end
   end

   // Once the run is well under way, starve the output for a long stretch while the
   // sender keeps offering, so the pipeline fills and the input stalls.
   initial begin
      wait (items_accepted >= HOLD_AFTER);
      hold_rsp = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_rsp = 1'b0;
   end

   function automatic lcd_cmd_s make_cmd(cmd_type cmd, logic [7:0] ch, logic signed [15:0] mv,
                                         logic [7:0] line_no, logic [7:0] col);
      lcd_cmd_s c;
      c.cmd     = cmd;
      c.ch      = ch;
      c.mv      = mv;
      c.line_no = line_no;
      c.col     = col;
      return c;
   endfunction

   // Mostly characters and moves so the address runs across row ends often;
   // positions are mostly in range for the current line mode, the rest are junk.
   function automatic lcd_cmd_s random_command();
      lcd_cmd_s c;
      int roll;
      roll      = $urandom_range(99);
      c.ch      = 8'($urandom);
      c.mv      = 16'($urandom);
      c.line_no = 8'($urandom);
      c.col     = 8'($urandom);
      if (roll < 45) begin
         c.cmd = CMD_CHAR;
      end else if (roll < 60) begin
         c.cmd = CMD_MOVE;
         if ($urandom_range(99) < 70) c.mv = 16'($urandom_range(200) - 100);
      end else if (roll < 75) begin
         c.cmd = CMD_SETPOS;
         if ($urandom_range(99) < 80) begin
            c.line_no = 8'($urandom_range(1));
            c.col     = 8'($urandom_range(sb.two_line ? ROW0_LEN : ONE_LINE_LEN));
         end
      end else if (roll < 80) begin
         c.cmd = CMD_CLEAR;
      end else if (roll < 85) begin
         c.cmd = CMD_HOME;
      end else if (roll < 91) begin
         c.cmd = CMD_TOGGLES;
      end else if (roll < 96) begin
         c.cmd = CMD_LINE_MODE;
      end else begin
         c.cmd = CMD_INIT;
      end
      return c;
   endfunction

   // Offer one item; valid is left high after acceptance so back-to-back items
   // carry straight on. The idle roll drops it for a gap first.
   task send_command(lcd_cmd_s c);
      @(negedge clock);
      while (!no_idle && $urandom_range(99) < 34) begin
         req_bus.valid = 1'b0;
         @(negedge clock);
      end
      req_bus.command     = c.cmd;
      req_bus.char_code   = c.ch;
      req_bus.move_amount = c.mv;
      req_bus.line_number = c.line_no;
      req_bus.column      = c.col;
      req_bus.valid       = 1'b1;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      sb.note_command(c);
      items_accepted++;
   endtask

   task write_register(logic [REG_W-1:0] idx, bit v);
      @(negedge clock);
      csr_bus.valid = 1'b1;
      csr_bus.index = idx;
      csr_bus.data  = v;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      sb.write_reg(idx, v);
   endtask

   // bit 0 backlight, 1 display, 2 cursor, 3 blink, 4 two-line
   task write_all(bit [4:0] v);
      write_register(REG_BACKLIGHT, v[0]);
      write_register(REG_DISPLAY,   v[1]);
      write_register(REG_CURSOR,    v[2]);
      write_register(REG_BLINK,     v[3]);
      write_register(REG_TWO_LINE,  v[4]);
      @(negedge clock);
      csr_bus.valid = 1'b0;
   endtask

   // Drop the input, wait for every expected byte, then let the block go quiet:
   // an invalid position produces nothing but still passes through the sequencer.
   task drain();
      @(negedge clock);
      req_bus.valid = 1'b0;
      while (sb.expected.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task send_random(int count);
      repeat (count) send_command(random_command());
   endtask

   initial begin
      int ph;
      reset               = 1'b1;
      req_bus.valid       = 1'b0;
      req_bus.command     = CMD_INIT;
      req_bus.char_code   = '0;
      req_bus.move_amount = '0;
      req_bus.line_number = '0;
      req_bus.column      = '0;
      rsp_bus.ready       = 1'b0;
      csr_bus.valid       = 1'b0;
      csr_bus.index       = REG_BACKLIGHT;
      csr_bus.data        = 1'b0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed, reset configuration (two-line): power-up, extreme characters,
      // both row-end wraps, extreme and zero moves, every kind of bad position,
      // then clear, home, toggles and line mode.
      send_command(make_cmd(CMD_INIT,      8'h00, 16'sh0000, 8'd0,   8'd0));
      send_command(make_cmd(CMD_CHAR,      8'h00, 16'sh0000, 8'd0,   8'd0));
      send_command(make_cmd(CMD_CHAR,      8'hFF, 16'sh7FFF, 8'hFF,  8'hFF));
      send_command(make_cmd(CMD_SETPOS,    8'h00, 16'sh0000, 8'd0,   8'h27));
      send_command(make_cmd(CMD_CHAR,      8'h41, 16'sh0000, 8'd0,   8'd0));
      send_command(make_cmd(CMD_SETPOS,    8'h00, 16'sh0000, 8'd1,   8'h27));
      send_command(make_cmd(CMD_CHAR,      8'h7E, 16'sh0000, 8'd0,   8'd0));
      send_command(make_cmd(CMD_MOVE,      8'h00, 16'sh7FFF, 8'd0,   8'd0));
      send_command(make_cmd(CMD_MOVE,      8'h00, 16'sh8000, 8'd0,   8'd0));
      send_command(make_cmd(CMD_MOVE,      8'h00, 16'sh0000, 8'd0,   8'd0));
      send_command(make_cmd(CMD_MOVE,      8'h00, -16'sd1,   8'd0,   8'd0));
      send_command(make_cmd(CMD_SETPOS,    8'h00, 16'sh0000, 8'd1,   8'h28));
      send_command(make_cmd(CMD_SETPOS,    8'h00, 16'sh0000, 8'd2,   8'd0));
      send_command(make_cmd(CMD_SETPOS,    8'h00, 16'sh0000, 8'hFF,  8'hFF));
      send_command(make_cmd(CMD_SETPOS,    8'h00, 16'sh0000, 8'd0,   8'h28));
      send_command(make_cmd(CMD_CLEAR,     8'h00, 16'sh0000, 8'd0,   8'd0));
      send_command(make_cmd(CMD_HOME,      8'h00, 16'sh0000, 8'd0,   8'd0));
      send_command(make_cmd(CMD_TOGGLES,   8'h00, 16'sh0000, 8'd0,   8'd0));
      send_command(make_cmd(CMD_LINE_MODE, 8'h00, 16'sh0000, 8'd0,   8'd0));
      drain();

      // Everything off, one-line: wrap at 0x50, line 1 and column 0x50 rejected,
      // a backward move from 0 lands on the last column.
      write_all(5'b00000);
      send_command(make_cmd(CMD_SETPOS,    8'h00, 16'sh0000, 8'd0,   8'h4F));
      send_command(make_cmd(CMD_CHAR,      8'h5A, 16'sh0000, 8'd0,   8'd0));
      send_command(make_cmd(CMD_SETPOS,    8'h00, 16'sh0000, 8'd1,   8'd0));
      send_command(make_cmd(CMD_SETPOS,    8'h00, 16'sh0000, 8'd0,   8'h50));
      send_command(make_cmd(CMD_MOVE,      8'h00, -16'sd1,   8'd0,   8'd0));
      send_random(PHASE_ITEMS);
      drain();

      // Everything on, and a stretch with no idling on either side.
      write_all(5'b11111);
      no_idle = 1'b1;
      send_random(PHASE_ITEMS);
      drain();
      no_idle = 1'b0;

      // Random settings; switching line mode mid-stream leaves odd addresses behind.
      for (ph = 0; ph < 4; ph++) begin
         write_all(5'($urandom));
         send_random(PHASE_ITEMS);
         drain();
      end

      if (sb.errors == 0)
         $display("char_lcd_nibble_bus_driver_tb: clean");
      else
         $display("char_lcd_nibble_bus_driver_tb: errors");
      $finish;
   end

endmodule
